[design/tfr_pkg.sv]
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and codes for the timestamped feature ring
// Operation, status and register index codes, plus the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tfr_pkg;

	localparam logic [2:0] OP_BEGIN = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_ADD   = 3'd2;
	localparam logic [2:0] OP_FIND  = 3'd3;
	localparam logic [2:0] OP_TRUNC = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_OOB  = 2'd3;

	localparam logic [1:0] REG_FEATURE_COUNT = 2'd0;
	localparam logic [1:0] REG_FEATURE_WORD  = 2'd1;
	localparam logic [1:0] REG_WINDOW        = 2'd2;

	typedef struct packed {
		logic clr_step;
		logic capture;
		logic begin_exec;
		logic feat_rd;
		logic feat_wr;
		logic res_oob;
		logic res_zero;
		logic walk_start;
		logic walk_rd;
		logic walk_step;
		logic walk_end;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       clr_last;
		logic       feat_oob;
		logic       walk_at_head;
		logic       walk_stop;
	} sts_t;

endpackage

[design/tfr_ctrl.sv]
// ----------------------------------------------------------------------------
// tfr_ctrl: sequencer for the timestamped feature ring
// Runs the clearing pass after reset, then steps each transaction through
// decode, feature access or ring walk, and hands the result to the output.
// ----------------------------------------------------------------------------
module tfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tfr_pkg::sts_t sts,
	output tfr_pkg::cmd_t cmd
);
	import tfr_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_FRD  = 3'd3;
	localparam logic [2:0] S_WCHK = 3'd4;
	localparam logic [2:0] S_WCMP = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.op) inside
					OP_BEGIN: begin
						cmd.begin_exec = 1'b1;
						state_d        = S_FIN;
					end
					OP_WRITE, OP_ADD, OP_READ: begin
						if (sts.feat_oob) begin
							cmd.res_oob = 1'b1;
							state_d     = S_FIN;
						end else begin
							cmd.feat_rd = 1'b1;
							state_d     = S_FRD;
						end
					end
					OP_FIND, OP_TRUNC: begin
						cmd.walk_start = 1'b1;
						state_d        = S_WCHK;
					end
					default: begin
						cmd.res_zero = 1'b1;
						state_d      = S_FIN;
					end
				endcase
			end
			S_FRD: begin
				cmd.feat_wr = 1'b1;
				state_d     = S_FIN;
			end
			S_WCHK: begin
				if (sts.walk_at_head) begin
					cmd.walk_end = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WCMP;
				end
			end
			S_WCMP: begin
				if (sts.walk_stop) begin
					cmd.walk_end = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_WCHK;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/tfr_dp.sv]
// ----------------------------------------------------------------------------
// tfr_dp: datapath of the timestamped feature ring
// Configuration registers, ring pointers, timestamp and feature memories,
// feature update logic, walk counter and the result and output registers.
// ----------------------------------------------------------------------------
module tfr_dp #(
	parameter int RING_ENTRIES = 256,
	parameter int MAX_FEATURES = 16,
	parameter int TIME_BITS    = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [2:0]          operation,
	input  logic [7:0]          entry_index,
	input  logic [3:0]          feature_index,
	input  logic signed [31:0]  value,
	input  logic [47:0]         timestamp,
	output logic [1:0]          status,
	output logic [7:0]          entry_out,
	output logic signed [31:0]  value_out,
	output logic [7:0]          skipped_count,
	output logic [7:0]          window_count,
	input  tfr_pkg::cmd_t       cmd,
	output tfr_pkg::sts_t       sts
);
	import tfr_pkg::*;

	localparam int PW         = $clog2(RING_ENTRIES);
	localparam int FEAT_DEPTH = RING_ENTRIES * MAX_FEATURES;
	localparam int CW         = $clog2(FEAT_DEPTH);
	localparam int AFW        = CW + 8;
	// ceil(2^16 / RING_ENTRIES): exact quotient for any 8-bit index
	localparam int RECIP      = (65536 + RING_ENTRIES - 1) / RING_ENTRIES;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		n = (p == PW'(RING_ENTRIES - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	logic [4:0]           fcount_q;
	logic [15:0]          fiw_q;
	logic [7:0]           window_q;

	logic [2:0]           op_q;
	logic [7:0]           idx_q;
	logic [7:0]           quo_q;
	logic [3:0]           feat_q;
	logic [31:0]          val_q;
	logic [TIME_BITS-1:0] ts_q;

	logic [PW-1:0]        head_q;
	logic [PW-1:0]        tail_q;
	logic [PW-1:0]        ptr_q;
	logic [7:0]           cnt_q;
	logic [CW-1:0]        clr_q;

	logic [TIME_BITS-1:0] time_mem [RING_ENTRIES];
	logic [TIME_BITS-1:0] time_rd_q;
	logic [31:0]          feat_mem [FEAT_DEPTH];
	logic [31:0]          feat_rd_q;

	logic [1:0]           res_status_q;
	logic [7:0]           res_entry_q;
	logic [31:0]          res_value_q;
	logic [7:0]           res_skip_q;

	logic [22:0]          quo_prod;
	logic [AFW-1:0]       addr_full;
	logic [CW-1:0]        feat_addr;
	logic [6:0]           nfeat;
	logic                 full;
	logic                 word;
	logic [31:0]          sum;
	logic [31:0]          cur;
	logic [31:0]          vout;
	logic                 feat_we;
	logic [CW-1:0]        feat_waddr;
	logic [31:0]          feat_wdata;

	assign quo_prod  = 23'(entry_index) * 23'(RECIP);
	assign addr_full = AFW'(idx_q) * AFW'(MAX_FEATURES) + AFW'(feat_q)
		- AFW'(quo_q) * AFW'(FEAT_DEPTH);
	assign feat_addr = addr_full[CW-1:0];
	assign nfeat     = (7'(fcount_q) > 7'(MAX_FEATURES)) ? 7'(MAX_FEATURES) : 7'(fcount_q);
	assign full      = (next_ptr(head_q) == tail_q);
	assign word      = fiw_q[feat_q];

	always_comb begin
		case (op_q)
			OP_WRITE: sum = val_q;
			OP_ADD:   sum = feat_rd_q + val_q;
			default:  sum = feat_rd_q;
		endcase
		cur  = word ? sum : {24'd0, sum[7:0]};
		vout = word ? cur : {{24{cur[7]}}, cur[7:0]};
	end

	assign feat_we    = cmd.clr_step | cmd.feat_wr;
	assign feat_waddr = cmd.clr_step ? clr_q : feat_addr;
	assign feat_wdata = cmd.clr_step ? 32'd0 : cur;

	assign sts.op           = op_q;
	assign sts.clr_last     = (clr_q == CW'(FEAT_DEPTH - 1));
	assign sts.feat_oob     = (7'(feat_q) >= nfeat);
	assign sts.walk_at_head = (ptr_q == head_q);
	assign sts.walk_stop    = (op_q == OP_FIND) ? (time_rd_q > ts_q) : !(time_rd_q < ts_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0;
			fiw_q    <= '0;
			window_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			clr_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FEATURE_COUNT: fcount_q <= cfg_data[4:0];
					REG_FEATURE_WORD:  fiw_q    <= cfg_data;
					REG_WINDOW:        window_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.begin_exec && !full) begin
				head_q <= next_ptr(head_q);
			end
			if (cmd.walk_start) begin
				ptr_q <= tail_q;
				cnt_q <= '0;
			end else if (cmd.walk_step) begin
				ptr_q <= next_ptr(ptr_q);
				if (cnt_q != 8'hFF) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.walk_end && op_q == OP_TRUNC) begin
				tail_q <= ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			idx_q  <= entry_index;
			quo_q  <= 8'(quo_prod >> 16);
			feat_q <= feature_index;
			val_q  <= value;
			ts_q   <= TIME_BITS'(timestamp);
		end
	end

	always_ff @(posedge clk) begin
		if (feat_we) begin
			feat_mem[feat_waddr] <= feat_wdata;
		end
		if (cmd.feat_rd) begin
			feat_rd_q <= feat_mem[feat_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_exec && !full) begin
			time_mem[head_q] <= ts_q;
		end
		if (cmd.walk_rd) begin
			time_rd_q <= time_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_exec) begin
			res_status_q <= full ? ST_FULL : ST_OK;
			res_entry_q  <= full ? 8'd0 : 8'(head_q);
			res_value_q  <= '0;
			res_skip_q   <= '0;
		end else if (cmd.res_oob) begin
			res_status_q <= ST_OOB;
			res_entry_q  <= '0;
			res_value_q  <= '0;
			res_skip_q   <= '0;
		end else if (cmd.res_zero) begin
			res_status_q <= ST_OK;
			res_entry_q  <= '0;
			res_value_q  <= '0;
			res_skip_q   <= '0;
		end else if (cmd.feat_wr) begin
			res_status_q <= ST_OK;
			res_entry_q  <= '0;
			res_value_q  <= vout;
			res_skip_q   <= '0;
		end else if (cmd.walk_end) begin
			res_status_q <= (op_q == OP_FIND && sts.walk_at_head) ? ST_NONE : ST_OK;
			res_entry_q  <= 8'(ptr_q);
			res_value_q  <= '0;
			res_skip_q   <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status        <= res_status_q;
			entry_out     <= res_entry_q;
			value_out     <= res_value_q;
			skipped_count <= res_skip_q;
			window_count  <= (res_skip_q > window_q) ? window_q : res_skip_q;
		end
	end

endmodule

[design/timestamped_feature_ring.sv]
// ----------------------------------------------------------------------------
// timestamped_feature_ring: ring of timestamped feature-vector records
// Input channel in_valid/in_stall carries one operation per transaction
// (begin, write, add, find after, truncate before, read); output channel
// out_valid/out_stall returns exactly one result per transaction. A
// transaction moves on an edge where valid is high and stall is low.
// Configuration (feature_count, feature_is_word, window) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. After reset the feature
// memory (RING_ENTRIES * MAX_FEATURES words, 4096 by default) is cleared
// one word per cycle; in_stall stays high until it is done. Configuration
// writes are taken during the clear. Items are processed one at a time.
// Begin, unknown operations and feature accesses outside the schema finish
// straight after decode; write/add/read do one feature memory read, then the
// write-back; find and truncate walk the ring from the tail, reading the
// timestamp of each entry they visit from the ring memory.
// The result becomes valid in the cycle the block can accept the next item.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile and held before its own output load.
// ----------------------------------------------------------------------------
module timestamped_feature_ring #(
	parameter int RING_ENTRIES = 256,
	parameter int MAX_FEATURES = 16,
	parameter int TIME_BITS    = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic [7:0]         entry_index,
	input  logic [3:0]         feature_index,
	input  logic signed [31:0] value,
	input  logic [47:0]        timestamp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [7:0]         entry_out,
	output logic signed [31:0] value_out,
	output logic [7:0]         skipped_count,
	output logic [7:0]         window_count
);
	import tfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tfr_dp #(
		.RING_ENTRIES (RING_ENTRIES),
		.MAX_FEATURES (MAX_FEATURES),
		.TIME_BITS    (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.entry_index   (entry_index),
		.feature_index (feature_index),
		.value         (value),
		.timestamp     (timestamp),
		.status        (status),
		.entry_out     (entry_out),
		.value_out     (value_out),
		.skipped_count (skipped_count),
		.window_count  (window_count),
		.cmd           (cmd),
		.sts           (sts)
	);

	// one transaction in flight: accept is followed by stall
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction is in flight");

	// output register is loaded only when its previous result is gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("stalled result overwritten");

	// clearing pass and feature write-back never share the write port
	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> (!cmd.feat_wr && in_stall))
		else $error("feature memory write conflict during clear");

endmodule

[bench/tb_timestamped_feature_ring.sv]
// ----------------------------------------------------------------------------
// tb_timestamped_feature_ring: self-checking bench for the feature ring
// A table of directed transactions (reset state, field extremes, byte/word
// wrap, empty ring, find and truncate edges, unknown opcodes) runs
// first, followed by random phases under different register settings. Every
// accepted transaction is run through a local predictor of the ring, and
// each returned result is compared field by field against the oldest
// expected result. Random stalls on both channels, a long output hold-off
// and a full ring fill are included; the final phase runs without idling.
// ----------------------------------------------------------------------------
module tb_timestamped_feature_ring;

	import tfr_pkg::*;

	localparam logic [2:0]  OP_RSV6 = 3'd6;
	localparam logic [2:0]  OP_RSV7 = 3'd7;
	localparam logic [47:0] TS_ONES = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  ent;
		logic [3:0]  feat;
		logic [31:0] val;
		logic [47:0] ts;
	} ring_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  entry;
		logic [31:0] val;
		logic [7:0]  skip;
		logic [7:0]  win;
	} ring_result_t;

	typedef enum logic [1:0] {ROW_SEND, ROW_CHECK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		ring_item_t   item;
		ring_result_t want;
		logic [1:0]   reg_sel;
		logic [15:0]  reg_val;
	} table_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         operation;
	logic [7:0]         entry_index;
	logic [3:0]         feature_index;
	logic signed [31:0] value;
	logic [47:0]        timestamp;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [7:0]         entry_out;
	logic signed [31:0] value_out;
	logic [7:0]         skipped_count;
	logic [7:0]         window_count;

	// predictor state
	logic [7:0]  head_q;
	logic [7:0]  tail_q;
	logic [47:0] stamp_mem [0:255];
	logic [31:0] feat_mem [0:4095];
	logic [4:0]  cfg_fcount;
	logic [15:0] cfg_word;
	logic [7:0]  cfg_window;
	logic [47:0] time_base;

	ring_result_t pending_results[$];
	table_row_t   directed_rows[$];
	int           ring_errors;
	bit           gaps_on;
	int           hold_left;

	timestamped_feature_ring DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.entry_index   (entry_index),
		.feature_index (feature_index),
		.value         (value),
		.timestamp     (timestamp),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.entry_out     (entry_out),
		.value_out     (value_out),
		.skipped_count (skipped_count),
		.window_count  (window_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#24000000;
		$display("timestamped_feature_ring verification failed");
		$finish;
	end

	function automatic logic [47:0] rand48();
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom;
		lo = $urandom;
		return {hi[15:0], lo};
	endfunction

	function automatic ring_result_t predict_ring_op(ring_item_t it);
		ring_result_t r;
		logic [7:0]   p;
		logic [7:0]   nxt;
		logic [11:0]  addr;
		logic [31:0]  cur;
		logic         wide;
		logic         hit;
		int           n;
		int           nf;
		r = '0;
		nf = (cfg_fcount > 16) ? 16 : cfg_fcount;
		case (it.op)
			OP_BEGIN: begin
				nxt = head_q + 8'd1;
				if (nxt == tail_q) begin
					r.status = ST_FULL;
				end else begin
					r.entry = head_q;
					stamp_mem[head_q] = it.ts;
					head_q = nxt;
				end
			end
			OP_WRITE, OP_ADD, OP_READ: begin
				if (int'(it.feat) >= nf) begin
					r.status = ST_OOB;
				end else begin
					addr = {it.ent, it.feat};
					wide = cfg_word[it.feat];
					cur = feat_mem[addr];
					if (it.op == OP_WRITE) cur = it.val;
					else if (it.op == OP_ADD) cur = cur + it.val;
					if (!wide) cur = {24'd0, cur[7:0]};
					feat_mem[addr] = cur;
					r.val = wide ? cur : {{24{cur[7]}}, cur[7:0]};
				end
			end
			OP_FIND: begin
				p = tail_q;
				n = 0;
				hit = 1'b0;
				while (p != head_q && !hit) begin
					if (stamp_mem[p] > it.ts) begin
						hit = 1'b1;
					end else begin
						p = p + 8'd1;
						n++;
					end
				end
				r.status = hit ? ST_OK : ST_NONE;
				r.entry = p;
				r.skip = (n > 255) ? 8'hFF : 8'(n);
			end
			OP_TRUNC: begin
				p = tail_q;
				n = 0;
				while (p != head_q && stamp_mem[p] < it.ts) begin
					p = p + 8'd1;
					n++;
				end
				tail_q = p;
				r.entry = p;
				r.skip = (n > 255) ? 8'hFF : 8'(n);
			end
			default: r = '0;
		endcase
		r.win = (r.skip > cfg_window) ? cfg_window : r.skip;
		return r;
	endfunction

	function automatic ring_item_t next_random_item();
		ring_item_t it;
		logic [7:0] occ;
		logic [7:0] idx;
		logic [47:0] t;
		int pick;
		int nf;
		nf = (cfg_fcount > 16) ? 16 : cfg_fcount;
		occ = head_q - tail_q;
		pick = $urandom_range(0, 99);
		it.ent = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
		if (nf > 0 && $urandom_range(0, 4) != 0) it.feat = 4'($urandom_range(0, nf - 1));
		else it.feat = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 5))
			0: it.val = 32'h7FFF_FFFF;
			1: it.val = 32'h8000_0000;
			2: it.val = $urandom_range(0, 255);
			3: it.val = 32'd0 - $urandom_range(1, 300);
			default: it.val = $urandom;
		endcase
		it.ts = rand48();
		if (pick < 26) begin
			it.op = OP_BEGIN;
			if ($urandom_range(0, 19) != 0) begin
				time_base = time_base + 48'($urandom_range(0, 3));
				it.ts = time_base;
			end
		end else if (pick < 40) begin
			it.op = OP_WRITE;
		end else if (pick < 54) begin
			it.op = OP_ADD;
		end else if (pick < 68) begin
			it.op = OP_READ;
		end else if (pick < 96) begin
			it.op = (pick < 82) ? OP_FIND : OP_TRUNC;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					if (occ != 0) begin
						idx = tail_q + 8'($urandom_range(0, occ - 1));
						t = stamp_mem[idx];
						it.ts = t + 48'($urandom_range(0, 2)) - 48'd1;
					end else begin
						it.ts = time_base;
					end
				end
				4, 5, 6: it.ts = time_base - 48'($urandom_range(0, 80));
				7: it.ts = '0;
				8: it.ts = TS_ONES;
				default: it.ts = rand48();
			endcase
		end else begin
			it.op = $urandom_range(0, 1) ? OP_RSV6 : OP_RSV7;
		end
		return it;
	endfunction

	task automatic tab_item(row_kind_t kind, ring_item_t it, ring_result_t want);
		table_row_t row;
		row = '0;
		row.kind = kind;
		row.item = it;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic tab_cfg(logic [1:0] sel, logic [15:0] val);
		table_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.reg_sel = sel;
		row.reg_val = val;
		directed_rows.push_back(row);
	endtask

	task automatic send_item(ring_item_t it, bit use_want, ring_result_t want);
		ring_result_t predicted;
		@(negedge clk);
		in_valid = 1'b1;
		operation = it.op;
		entry_index = it.ent;
		feature_index = it.feat;
		value = it.val;
		timestamp = it.ts;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = predict_ring_op(it);
		pending_results.push_back(use_want ? want : predicted);
	endtask

	task automatic sender_gap();
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] sel, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (sel)
			REG_FEATURE_COUNT: cfg_fcount = val[4:0];
			REG_FEATURE_WORD:  cfg_word = val;
			REG_WINDOW:        cfg_window = val[7:0];
			default: ;
		endcase
	endtask

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			ring_errors++;
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				ring_errors++;
				$error("result with no transaction pending: status %0d entry %0d",
					status, entry_out);
			end else begin
				want = pending_results.pop_front();
				cmp_field("status", 32'(want.status), 32'(status));
				cmp_field("entry_out", 32'(want.entry), 32'(entry_out));
				cmp_field("value_out", want.val, value_out);
				cmp_field("skipped_count", 32'(want.skip), 32'(skipped_count));
				cmp_field("window_count", 32'(want.win), 32'(window_count));
			end
		end
	end

	// output side: random stall bursts, or a long hold-off when requested
	initial begin
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if (gaps_on && $urandom_range(0, 99) < 15) begin
				out_stall = 1'b1;
				burst = $urandom_range(0, 5);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		table_row_t  row;
		ring_item_t  it;
		logic [4:0]  fc;
		logic [15:0] wd;
		logic [7:0]  win;
		logic [31:0] junk;
		int          ph;
		int          k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = '0;
		entry_index = '0;
		feature_index = '0;
		value = '0;
		timestamp = '0;
		head_q = '0;
		tail_q = '0;
		cfg_fcount = '0;
		cfg_word = '0;
		cfg_window = '0;
		ring_errors = 0;
		gaps_on = 1'b1;
		hold_left = 0;
		foreach (stamp_mem[i]) stamp_mem[i] = '0;
		foreach (feat_mem[i]) feat_mem[i] = '0;
		time_base = rand48() & 48'h0FFF_FFFF_FFFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers still at reset: no features, window zero, empty ring
		tab_item(ROW_CHECK, {OP_READ, 8'd0, 4'd0, 32'd0, 48'd0},
			{ST_OOB, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_WRITE, 8'd7, 4'd15, 32'hFFFF_FFFF, 48'd0},
			{ST_OOB, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_FIND, 8'd0, 4'd0, 32'd0, 48'd0},
			{ST_NONE, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_TRUNC, 8'd0, 4'd0, 32'd0, TS_ONES},
			{ST_OK, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_RSV6, 8'hFF, 4'hF, 32'hFFFF_FFFF, TS_ONES},
			{ST_OK, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_RSV7, 8'hFF, 4'hF, 32'hFFFF_FFFF, TS_ONES},
			{ST_OK, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_cfg(REG_FEATURE_COUNT, 16'hFFFF);
		tab_cfg(REG_FEATURE_WORD, 16'hAAAA);
		tab_cfg(REG_WINDOW, 16'h0F02);
		// odd features are words, even ones bytes
		tab_item(ROW_CHECK, {OP_WRITE, 8'd255, 4'd15, 32'h7FFF_FFFF, 48'd0},
			{ST_OK, 8'd0, 32'h7FFF_FFFF, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_ADD, 8'd255, 4'd15, 32'd1, 48'd0},
			{ST_OK, 8'd0, 32'h8000_0000, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_READ, 8'd255, 4'd15, 32'd0, 48'd0},
			{ST_OK, 8'd0, 32'h8000_0000, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_WRITE, 8'd0, 4'd0, 32'h0000_0080, 48'd0},
			{ST_OK, 8'd0, 32'hFFFF_FF80, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_ADD, 8'd0, 4'd0, 32'h0000_007F, 48'd0},
			{ST_OK, 8'd0, 32'hFFFF_FFFF, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_ADD, 8'd0, 4'd0, 32'd1, 48'd0},
			{ST_OK, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_WRITE, 8'd1, 4'd14, 32'h1234_5678, 48'd0},
			{ST_OK, 8'd0, 32'h0000_0078, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_ADD, 8'd0, 4'd1, 32'h8000_0000, 48'd0},
			{ST_OK, 8'd0, 32'h8000_0000, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_BEGIN, 8'd0, 4'd0, 32'd0, 48'd100},
			{ST_OK, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_BEGIN, 8'd0, 4'd0, 32'd0, 48'd200},
			{ST_OK, 8'd1, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_BEGIN, 8'd0, 4'd0, 32'd0, 48'd300},
			{ST_OK, 8'd2, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_BEGIN, 8'd0, 4'd0, 32'd0, TS_ONES},
			{ST_OK, 8'd3, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_CHECK, {OP_FIND, 8'd0, 4'd0, 32'd0, 48'd150},
			{ST_OK, 8'd1, 32'd0, 8'd1, 8'd1});
		tab_item(ROW_CHECK, {OP_FIND, 8'd0, 4'd0, 32'd0, TS_ONES},
			{ST_NONE, 8'd4, 32'd0, 8'd4, 8'd2});
		tab_item(ROW_CHECK, {OP_TRUNC, 8'd0, 4'd0, 32'd0, 48'd300},
			{ST_OK, 8'd2, 32'd0, 8'd2, 8'd2});
		tab_item(ROW_CHECK, {OP_FIND, 8'd0, 4'd0, 32'd0, 48'd0},
			{ST_OK, 8'd2, 32'd0, 8'd0, 8'd0});
		tab_cfg(REG_FEATURE_COUNT, 16'h0003);
		tab_cfg(REG_WINDOW, 16'h00FF);
		tab_item(ROW_CHECK, {OP_READ, 8'd0, 4'd3, 32'd0, 48'd0},
			{ST_OOB, 8'd0, 32'd0, 8'd0, 8'd0});
		tab_item(ROW_SEND, {OP_READ, 8'd1, 4'd2, 32'd0, 48'd0}, '0);
		tab_item(ROW_CHECK, {OP_TRUNC, 8'd0, 4'd0, 32'd0, TS_ONES},
			{ST_OK, 8'd3, 32'd0, 8'd1, 8'd1});
		tab_item(ROW_SEND, {OP_BEGIN, 8'd0, 4'd0, 32'd0, 48'd0}, '0);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_CFG: begin
					settle();
					write_reg(row.reg_sel, row.reg_val);
				end
				ROW_CHECK: send_item(row.item, 1'b1, row.want);
				default: send_item(row.item, 1'b0, '0);
			endcase
		end

		for (ph = 0; ph < 6; ph++) begin
			settle();
			gaps_on = (ph != 5);
			case (ph)
				0: begin
					fc = 5'd16;
					wd = 16'hFFFF;
					win = 8'd0;
				end
				1: begin
					fc = 5'd0;
					wd = 16'h0000;
					win = 8'd255;
				end
				2: begin
					fc = 5'd31;
					wd = 16'($urandom);
					win = 8'($urandom_range(1, 254));
				end
				3: begin
					fc = 5'($urandom_range(1, 15));
					wd = 16'($urandom);
					win = 8'($urandom_range(0, 255));
				end
				4: begin
					fc = 5'($urandom_range(17, 31));
					wd = 16'h5555;
					win = 8'd1;
				end
				default: begin
					fc = 5'($urandom_range(0, 31));
					wd = 16'($urandom);
					win = 8'($urandom_range(0, 255));
				end
			endcase
			junk = $urandom;
			write_reg(REG_FEATURE_COUNT, {junk[15:5], fc});
			write_reg(REG_FEATURE_WORD, wd);
			write_reg(REG_WINDOW, {junk[31:24], win});

			if (ph == 1) begin
				// run the ring into full, then flush it
				for (k = 0; k < 260; k++) begin
					time_base = time_base + 48'd1;
					it = '0;
					it.op = OP_BEGIN;
					it.ent = 8'($urandom_range(0, 255));
					it.ts = time_base;
					send_item(it, 1'b0, '0);
					sender_gap();
				end
				it = '0;
				it.op = OP_TRUNC;
				it.ts = TS_ONES;
				send_item(it, 1'b0, '0);
			end
			if (ph == 2)
				hold_left = 400;

			for (k = 0; k < 110; k++) begin
				if (ph == 3 && k == 55)
					settle();
				send_item(next_random_item(), 1'b0, '0);
				sender_gap();
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		for (k = 0; k < 5000 && pending_results.size() != 0; k++)
			@(posedge clk);
		if (pending_results.size() != 0) begin
			ring_errors++;
			$error("%0d transactions never returned a result", pending_results.size());
		end
		repeat (10) @(posedge clk);
		if (ring_errors == 0) begin
			$display("timestamped_feature_ring verification clean");
		end else begin
			$display("timestamped_feature_ring verification failed");
		end
		$finish;
	end

endmodule
